>>> design/ufbd_pkg.sv
// Shared types and constants for the fractional baud divisor.
`default_nettype none
package ufbd_pkg;

  // Dividend: 3 MHz expressed in eighths of a divisor step
  localparam int unsigned NUM_W = 25;
  localparam logic [NUM_W-1:0] CLK_EIGHTHS = 25'd24000000;

  localparam logic [23:0] FAST_LIMIT = 24'd2000000;
  localparam logic [23:0] MED_RATE_IN = 24'd1000000;
  localparam logic [23:0] MIN_RATE = 24'd184;

  localparam logic [21:0] FAST_RATE = 22'd3000000;
  localparam logic [21:0] MED_RATE = 22'd1000000;
  localparam logic [21:0] SAT_RATE = 22'd183;
  localparam logic [17:0] MAX_EIGHTHS = 18'd131071;

  // Request class, decided at the input
  typedef enum logic [1:0] {
    CLS_NORM = 2'd0,
    CLS_FAST = 2'd1,
    CLS_MED = 2'd2,
    CLS_SLOW = 2'd3
  } rate_cls_t;

  // Fraction code by eighths
  function automatic logic [2:0] frac_code(input logic [2:0] eighth);
    logic [2:0] code;
    unique case (eighth)
      3'd0: code = 3'd0;
      3'd1: code = 3'd3;
      3'd2: code = 3'd2;
      3'd3: code = 3'd4;
      3'd4: code = 3'd1;
      3'd5: code = 3'd5;
      3'd6: code = 3'd6;
      default: code = 3'd7;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

>>> design/uart_fractional_baud_divisor.sv
// Top level: UART fractional baud divisor in eighths, fully pipelined.
//
//  channel | direction | fields
//  --------+-----------+-------------------------------------------------------
//  in_     | input     | baud_rate[23:0]
//  out_    | output    | divisor_value[15:0], divisor_index, actual_rate, rate_error
//
// One transfer in per cycle while the output is not stalled: 25 stages for
// k = 24e6/rate, 25 stages for the two parallel quotients 24e6/k and 24e6/(k+1),
// one output register for the error compare and code mapping.
// Reset clears the valid bits only. A stall on the output freezes the whole
// pipeline in place, so nothing is lost or repeated.
`default_nettype none
module uart_fractional_baud_divisor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_baud_rate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_divisor_value,
  output logic             out_divisor_index,
  output logic [21:0]      out_actual_rate,
  output logic             out_rate_error
);
  import ufbd_pkg::*;

  logic en;
  logic out_valid_r;
  logic [15:0] value_r;
  logic        index_r;
  logic [21:0] actual_r;
  logic        err_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // classify the request
  rate_cls_t in_cls;
  always_comb begin
    priority if (in_baud_rate > FAST_LIMIT) in_cls = CLS_FAST;
    else if (in_baud_rate >= MED_RATE_IN)   in_cls = CLS_MED;
    else if (in_baud_rate < MIN_RATE)       in_cls = CLS_SLOW;
    else                                    in_cls = CLS_NORM;
  end

  // first divider: k = 24e6 / rate
  logic              d1_vld;
  logic [NUM_W-1:0]  d1_quo;
  logic [21:0]       d1_side;

  ufbd_div #(.DW(20), .SW(22)) u_div_k (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_den   (in_baud_rate[19:0]),
    .in_side  ({in_baud_rate[19:0], in_cls}),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  logic [16:0] k_val;
  logic [17:0] k_inc;
  assign k_val = d1_quo[16:0];
  assign k_inc = {1'b0, k_val} + 18'd1;

  // second level: lo rate with k+1, hi rate with k
  logic              lo_vld;
  logic [NUM_W-1:0]  lo_quo;
  logic [19:0]       lo_side;
  logic              hi_vld;
  logic [NUM_W-1:0]  hi_quo;
  logic [18:0]       hi_side;

  ufbd_div #(.DW(18), .SW(20)) u_div_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d1_vld),
    .in_den   (k_inc),
    .in_side  (d1_side[21:2]),
    .out_vld  (lo_vld),
    .out_quo  (lo_quo),
    .out_side (lo_side)
  );

  ufbd_div #(.DW(18), .SW(19)) u_div_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d1_vld),
    .in_den   ({1'b0, k_val}),
    .in_side  ({k_val, d1_side[1:0]}),
    .out_vld  (hi_vld),
    .out_quo  (hi_quo),
    .out_side (hi_side)
  );

  // pick the divisor with the smaller error (k+1 on a tie) and encode it; fast, medium and slow classes override
  logic [19:0] rate_q, lo_rate, hi_rate, err_up, err_dn;
  logic [16:0] k_q;
  rate_cls_t   cls_q;
  logic        pick_k;
  logic [17:0] chosen;
  logic [2:0]  code;
  logic [15:0] value_nxt;
  logic        index_nxt;
  logic [21:0] actual_nxt;
  logic        err_nxt;

  always_comb begin
    rate_q  = lo_side;
    k_q     = hi_side[18:2];
    cls_q   = rate_cls_t'(hi_side[1:0]);
    lo_rate = lo_quo[19:0];
    hi_rate = hi_quo[19:0];
    err_up  = rate_q - lo_rate;
    err_dn  = hi_rate - rate_q;
    pick_k  = (err_dn < err_up);
    chosen  = pick_k ? {1'b0, k_q} : ({1'b0, k_q} + 18'd1);
    if (cls_q == CLS_SLOW) chosen = MAX_EIGHTHS;
    code = frac_code(chosen[2:0]);
    value_nxt  = {code[1:0], chosen[16:3]};
    index_nxt  = code[2];
    actual_nxt = pick_k ? {2'b00, hi_rate} : {2'b00, lo_rate};
    err_nxt    = 1'b0;
    unique case (cls_q)
      CLS_FAST: begin
        value_nxt  = 16'd0;
        index_nxt  = 1'b0;
        actual_nxt = FAST_RATE;
      end
      CLS_MED: begin
        value_nxt  = 16'd1;
        index_nxt  = 1'b0;
        actual_nxt = MED_RATE;
      end
      CLS_SLOW: begin
        actual_nxt = SAT_RATE;
        err_nxt    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lo_vld;
    end
    if (en) begin
      value_r  <= value_nxt;
      index_r  <= index_nxt;
      actual_r <= actual_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_divisor_value = value_r;
  assign out_divisor_index = index_r;
  assign out_actual_rate   = actual_r;
  assign out_rate_error    = err_r;

  // both second-level dividers run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) lo_vld == hi_vld)
    else $error("second-level dividers out of step");

  // saturated result carries the full code
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_error |->
      out_divisor_value == 16'hFFFF && out_divisor_index && out_actual_rate == SAT_RATE)
    else $error("saturated result malformed");

  // achieved rate is never zero nor above the fast rate
  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_actual_rate != 22'd0 && out_actual_rate <= FAST_RATE)
    else $error("achieved rate out of range");

endmodule
`default_nettype wire

>>> design/ufbd_div.sv
// Pipelined restoring divider: fixed dividend over a variable divisor, one bit a stage.
`default_nettype none
module ufbd_div #(
  parameter int unsigned DW = 20,
  parameter int unsigned SW = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [DW-1:0]                 in_den,
  input  wire logic [SW-1:0]                 in_side,
  output logic                               out_vld,
  output logic [ufbd_pkg::NUM_W-1:0]         out_quo,
  output logic [SW-1:0]                      out_side
);
  import ufbd_pkg::*;

  localparam int unsigned NB = NUM_W;

  logic [NB-1:0] vld_r;
  logic [DW-1:0] rem_r  [NB];
  logic [NB-1:0] quo_r  [NB];
  logic [DW-1:0] den_r  [NB];
  logic [SW-1:0] side_r [NB];

  genvar s;
  generate
    for (s = 0; s < NB; s++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [NB-1:0] quo_prev;
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic          vld_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_nxt;
      logic [NB-1:0] quo_nxt;

      if (s == 0) begin : g_first
        assign rem_prev  = '0;
        assign quo_prev  = '0;
        assign den_prev  = in_den;
        assign side_prev = in_side;
        assign vld_prev  = in_vld;
      end else begin : g_next
        assign rem_prev  = rem_r[s-1];
        assign quo_prev  = quo_r[s-1];
        assign den_prev  = den_r[s-1];
        assign side_prev = side_r[s-1];
        assign vld_prev  = vld_r[s-1];
      end

      // shift in the next dividend bit, subtract if it fits
      always_comb begin
        trial   = {rem_prev, CLK_EIGHTHS[NB-1-s]};
        ge      = (trial >= {1'b0, den_prev});
        diff    = trial - {1'b0, den_prev};
        rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_nxt = quo_prev;
        quo_nxt[NB-1-s] = ge;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (en) begin
          vld_r[s] <= vld_prev;
        end
        if (en) begin
          rem_r[s]  <= rem_nxt;
          quo_r[s]  <= quo_nxt;
          den_r[s]  <= den_prev;
          side_r[s] <= side_prev;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[NB-1];
  assign out_quo  = quo_r[NB-1];
  assign out_side = side_r[NB-1];

endmodule
`default_nettype wire

>>> dv/uart_fractional_baud_divisor_test.sv
// Self-checking testbench for the fractional baud divisor: queued driver, clocked monitor.
`default_nettype none
module uart_fractional_baud_divisor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ufbd_pkg::*;

  typedef struct packed {
    logic [15:0] divisor_value;
    logic        divisor_index;
    logic [21:0] actual_rate;
    logic        rate_error;
  } divisor_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_baud_rate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_divisor_value;
  logic        out_divisor_index;
  logic [21:0] out_actual_rate;
  logic        out_rate_error;

  logic [23:0]  pending_rates[$];
  divisor_res_t expected_divisors[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sent_count = 0;
  int unsigned  recv_count = 0;
  bit           stim_done = 1'b0;
  bit           quiet = 1'b0;

  uart_fractional_baud_divisor dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the divisor code for one requested rate
  function automatic divisor_res_t predict_divisor(logic [23:0] rate);
    divisor_res_t r;
    logic [31:0] k, lo_rate, hi_rate, err_up, err_dn, chosen;
    logic [2:0]  code;
    r = '0;
    if (rate > FAST_LIMIT) begin
      r.actual_rate = FAST_RATE;
    end else if (rate >= MED_RATE_IN) begin
      r.divisor_value = 16'd1;
      r.actual_rate = MED_RATE;
    end else begin
      if (rate < MIN_RATE) begin
        chosen = 32'd131071;
        r.rate_error = 1'b1;
      end else begin
        k = 32'd24000000 / rate;
        lo_rate = 32'd24000000 / (k + 1);
        hi_rate = 32'd24000000 / k;
        err_up = rate - lo_rate;
        err_dn = hi_rate - rate;
        chosen = (err_dn < err_up) ? k : k + 1;
      end
      r.actual_rate = 22'(32'd24000000 / chosen);
      case (chosen[2:0])
        3'd0: code = 3'd0;
        3'd1: code = 3'd3;
        3'd2: code = 3'd2;
        3'd3: code = 3'd4;
        3'd4: code = 3'd1;
        3'd5: code = 3'd5;
        3'd6: code = 3'd6;
        default: code = 3'd7;
      endcase
      r.divisor_value = {code[1:0], chosen[16:3]};
      r.divisor_index = code[2];
    end
    return r;
  endfunction

  // Driver: present queued rates, random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_divisors.push_back(predict_divisor(in_baud_rate));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_rates.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
          in_valid <= 1'b1;
          in_baud_rate <= pending_rates.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    divisor_res_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        recv_count++;
        if (expected_divisors.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          exp_r = expected_divisors.pop_front();
          if (out_divisor_value !== exp_r.divisor_value) begin
            $error("divisor_value exp %h got %h", exp_r.divisor_value, out_divisor_value);
            fail_count++;
          end
          if (out_divisor_index !== exp_r.divisor_index) begin
            $error("divisor_index exp %b got %b", exp_r.divisor_index, out_divisor_index);
            fail_count++;
          end
          if (out_actual_rate !== exp_r.actual_rate) begin
            $error("actual_rate exp %0d got %0d", exp_r.actual_rate, out_actual_rate);
            fail_count++;
          end
          if (out_rate_error !== exp_r.rate_error) begin
            $error("rate_error exp %b got %b", exp_r.rate_error, out_rate_error);
            fail_count++;
          end
        end
      end
      out_ready <= quiet || $urandom_range(99) >= 16;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("uart_fractional_baud_divisor verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    logic [23:0] r;
    // Directed: band edges, saturation, extremes, whole divisors
    pending_rates = '{24'd0, 24'd1, 24'd183, 24'd184, 24'd185, 24'd300, 24'd9600,
                      24'd115200, 24'd3000, 24'd6000, 24'd999999, 24'd1000000,
                      24'd1500000, 24'd2000000, 24'd2000001, 24'd3000000,
                      24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'd750000, 24'd12000,
                      24'd187500, 24'd46875};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 550; i++) begin
      sel = $urandom_range(9);
      case (sel)
        0: r = 24'($urandom());
        1: r = 24'($urandom_range(300));
        2: r = 24'($urandom_range(2100000, 900000));
        3: r = 24'($urandom_range(20000, 184));
        default: r = 24'($urandom_range(999999, 184));
      endcase
      pending_rates.push_back(r);
    end
    // Stretch with no idling in the middle of the random part
    wait (pending_rates.size() < 300);
    quiet = 1'b1;
    wait (pending_rates.size() < 150);
    quiet = 1'b0;
    wait (pending_rates.size() == 0 && !in_valid);
    stim_done = 1'b1;
    wait (expected_divisors.size() == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d rate requests, checked %0d divisor results across all bands",
             sent_count, recv_count);
    if (stim_done && fail_count == 0 && expected_divisors.size() == 0)
      $display("uart_fractional_baud_divisor verification clean");
    else
      $display("uart_fractional_baud_divisor verification failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
design/ufbd_pkg.sv
design/ufbd_div.sv
design/uart_fractional_baud_divisor.sv
dv/uart_fractional_baud_divisor_test.sv
